// ===== rtl/rtnh_pkg.sv =====
// Package for the ray/triangle nearest-hit block: payload types, widths,
// register indexes and the multiply sequence table. No dependencies.
package rtnh_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIST_WIDTH  = 32;
    localparam int QUOT_SHIFT  = 22;                   // 16 + 14 - 8
    localparam int EW          = COORD_WIDTH + 1;      // edge vectors
    localparam int PW          = 2 * COORD_WIDTH + 2;  // cross products
    localparam int SW          = 3 * COORD_WIDTH + 5;  // dot products
    localparam int RW          = SW + DIST_WIDTH;      // divider remainder
    localparam int MUL_STEPS   = 24;
    localparam int DIV_STEPS   = DIST_WIDTH - 1;
    localparam int STEP_W      = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_MIN  = 3'd6;

    localparam logic signed [COORD_WIDTH-1:0] DIR_Z_RESET = COORD_WIDTH'(16384);
    localparam logic signed [DIST_WIDTH-1:0]  DIST_MAX    = {1'b0, {(DIST_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
        logic                          last_triangle;
    } t_tri_in;

    typedef struct packed {
        logic                         hit;
        logic signed [DIST_WIDTH-1:0] distance;
        logic signed [DIST_WIDTH-1:0] nearest;
        logic                         batch_done;
    } t_hit_out;

    typedef enum logic [1:0] {A_DIR, A_E1, A_E2, A_T} t_asel;
    typedef enum logic [1:0] {B_E1, B_E2, B_P, B_Q} t_bsel;
    typedef enum logic [2:0] {D_P, D_Q, D_DET, D_U, D_V, D_N} t_dst;

    typedef struct packed {
        t_asel      asel;
        logic [1:0] acomp;
        t_bsel      bsel;
        logic [1:0] bcomp;
        t_dst       dst;
        logic [1:0] dcomp;
        logic       first;
        logic       sub;
    } t_mstep;

    typedef struct packed {
        logic              load;
        logic              mul_en;
        logic [STEP_W-1:0] step;
        logic              check;
        logic              div_init;
        logic              div_step;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_sts;

    function automatic t_mstep mk(t_asel as, logic [1:0] ac, t_bsel bs, logic [1:0] bc,
                                  t_dst ds, logic [1:0] dc, logic fi, logic su);
        t_mstep r;
        r.asel  = as;
        r.acomp = ac;
        r.bsel  = bs;
        r.bcomp = bc;
        r.dst   = ds;
        r.dcomp = dc;
        r.first = fi;
        r.sub   = su;
        return r;
    endfunction

    // p = dir x e2, q = t x e1, then det, u, v and the distance numerator.
    function automatic t_mstep mstep_at(logic [STEP_W-1:0] s);
        t_mstep r;
        case (s)
            5'd0:  r = mk(A_DIR, 2'd1, B_E2, 2'd2, D_P, 2'd0, 1'b1, 1'b0);
            5'd1:  r = mk(A_DIR, 2'd2, B_E2, 2'd1, D_P, 2'd0, 1'b0, 1'b1);
            5'd2:  r = mk(A_DIR, 2'd2, B_E2, 2'd0, D_P, 2'd1, 1'b1, 1'b0);
            5'd3:  r = mk(A_DIR, 2'd0, B_E2, 2'd2, D_P, 2'd1, 1'b0, 1'b1);
            5'd4:  r = mk(A_DIR, 2'd0, B_E2, 2'd1, D_P, 2'd2, 1'b1, 1'b0);
            5'd5:  r = mk(A_DIR, 2'd1, B_E2, 2'd0, D_P, 2'd2, 1'b0, 1'b1);
            5'd6:  r = mk(A_T,   2'd1, B_E1, 2'd2, D_Q, 2'd0, 1'b1, 1'b0);
            5'd7:  r = mk(A_T,   2'd2, B_E1, 2'd1, D_Q, 2'd0, 1'b0, 1'b1);
            5'd8:  r = mk(A_T,   2'd2, B_E1, 2'd0, D_Q, 2'd1, 1'b1, 1'b0);
            5'd9:  r = mk(A_T,   2'd0, B_E1, 2'd2, D_Q, 2'd1, 1'b0, 1'b1);
            5'd10: r = mk(A_T,   2'd0, B_E1, 2'd1, D_Q, 2'd2, 1'b1, 1'b0);
            5'd11: r = mk(A_T,   2'd1, B_E1, 2'd0, D_Q, 2'd2, 1'b0, 1'b1);
            5'd12: r = mk(A_E1,  2'd0, B_P,  2'd0, D_DET, 2'd0, 1'b1, 1'b0);
            5'd13: r = mk(A_E1,  2'd1, B_P,  2'd1, D_DET, 2'd0, 1'b0, 1'b0);
            5'd14: r = mk(A_E1,  2'd2, B_P,  2'd2, D_DET, 2'd0, 1'b0, 1'b0);
            5'd15: r = mk(A_T,   2'd0, B_P,  2'd0, D_U, 2'd0, 1'b1, 1'b0);
            5'd16: r = mk(A_T,   2'd1, B_P,  2'd1, D_U, 2'd0, 1'b0, 1'b0);
            5'd17: r = mk(A_T,   2'd2, B_P,  2'd2, D_U, 2'd0, 1'b0, 1'b0);
            5'd18: r = mk(A_DIR, 2'd0, B_Q,  2'd0, D_V, 2'd0, 1'b1, 1'b0);
            5'd19: r = mk(A_DIR, 2'd1, B_Q,  2'd1, D_V, 2'd0, 1'b0, 1'b0);
            5'd20: r = mk(A_DIR, 2'd2, B_Q,  2'd2, D_V, 2'd0, 1'b0, 1'b0);
            5'd21: r = mk(A_E2,  2'd0, B_Q,  2'd0, D_N, 2'd0, 1'b1, 1'b0);
            5'd22: r = mk(A_E2,  2'd1, B_Q,  2'd1, D_N, 2'd0, 1'b0, 1'b0);
            5'd23: r = mk(A_E2,  2'd2, B_Q,  2'd2, D_N, 2'd0, 1'b0, 1'b0);
            default: r = mk(A_DIR, 2'd0, B_E1, 2'd0, D_P, 2'd0, 1'b1, 1'b0);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/rtnh_datapath.sv =====
// Datapath: ray registers, shared multiplier with accumulator, hit test,
// restoring divider and the result register. Depends on rtnh_pkg.
module rtnh_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [rtnh_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rtnh_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  rtnh_pkg::t_tri_in                      i_data,
    input  rtnh_pkg::t_cmd                         i_cmd,
    output rtnh_pkg::t_sts                         o_sts,
    output rtnh_pkg::t_hit_out                     o_data
);

    localparam int CW = rtnh_pkg::COORD_WIDTH;
    localparam int EW = rtnh_pkg::EW;
    localparam int PW = rtnh_pkg::PW;
    localparam int SW = rtnh_pkg::SW;
    localparam int RW = rtnh_pkg::RW;
    localparam int DW = rtnh_pkg::DIST_WIDTH;

    logic signed [CW-1:0] r_org [3];
    logic signed [CW-1:0] r_dir [3];
    logic [15:0]          r_det_min;

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [EW-1:0] r_t  [3];
    logic signed [PW-1:0] r_p  [3];
    logic signed [PW-1:0] r_q  [3];
    logic signed [SW-1:0] r_det, r_u, r_v, r_n;
    logic                 r_last;

    logic                       r_mv;
    rtnh_pkg::t_mstep           r_ms;
    logic signed [EW+PW-1:0]    r_prod;

    logic                 r_hit, r_neg, r_sat;
    logic [SW-1:0]        r_nabs;
    logic [RW-1:0]        r_rem, r_dsh;
    logic [DW-2:0]        r_quo;
    logic signed [DW-1:0] r_near;
    rtnh_pkg::t_hit_out   r_out;

    logic signed [CW-1:0] va [3], vb [3], vc [3];
    logic signed [EW-1:0] a_vec [3];
    logic signed [PW-1:0] b_vec [3];
    logic signed [EW-1:0] a_op;
    logic signed [PW-1:0] b_op;
    rtnh_pkg::t_mstep     ms;
    logic signed [SW-1:0] acc_cur, acc_base, acc_res;
    logic signed [SW-1:0] dmin;
    logic signed [SW:0]   uv, det_x;
    logic                 ok;
    logic [RW-1:0]        num_sh, det_top;
    logic                 ge;
    logic [DW-1:0]        lim, mag;
    logic signed [DW-1:0] sdist, res_dist, new_near;

    // Ray configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_dir[0]  <= '0;
            r_dir[1]  <= '0;
            r_dir[2]  <= rtnh_pkg::DIR_Z_RESET;
            r_det_min <= 16'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rtnh_pkg::CFG_ORIGIN_X: r_org[0]  <= i_cfg_data;
                rtnh_pkg::CFG_ORIGIN_Y: r_org[1]  <= i_cfg_data;
                rtnh_pkg::CFG_ORIGIN_Z: r_org[2]  <= i_cfg_data;
                rtnh_pkg::CFG_DIR_X:    r_dir[0]  <= i_cfg_data;
                rtnh_pkg::CFG_DIR_Y:    r_dir[1]  <= i_cfg_data;
                rtnh_pkg::CFG_DIR_Z:    r_dir[2]  <= i_cfg_data;
                rtnh_pkg::CFG_DET_MIN:  r_det_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        va[0] = i_data.a_x; va[1] = i_data.a_y; va[2] = i_data.a_z;
        vb[0] = i_data.b_x; vb[1] = i_data.b_y; vb[2] = i_data.b_z;
        vc[0] = i_data.c_x; vc[1] = i_data.c_y; vc[2] = i_data.c_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EW'(vb[k]) - EW'(va[k]);
                r_e2[k] <= EW'(vc[k]) - EW'(va[k]);
                r_t[k]  <= EW'(r_org[k]) - EW'(va[k]);
            end
            r_last <= i_data.last_triangle;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        ms = rtnh_pkg::mstep_at(i_cmd.step);
        for (int k = 0; k < 3; k++) begin
            case (ms.asel)
                rtnh_pkg::A_DIR: a_vec[k] = EW'(r_dir[k]);
                rtnh_pkg::A_E1:  a_vec[k] = r_e1[k];
                rtnh_pkg::A_E2:  a_vec[k] = r_e2[k];
                rtnh_pkg::A_T:   a_vec[k] = r_t[k];
                default:         a_vec[k] = '0;
            endcase
            case (ms.bsel)
                rtnh_pkg::B_E1: b_vec[k] = PW'(r_e1[k]);
                rtnh_pkg::B_E2: b_vec[k] = PW'(r_e2[k]);
                rtnh_pkg::B_P:  b_vec[k] = r_p[k];
                rtnh_pkg::B_Q:  b_vec[k] = r_q[k];
                default:        b_vec[k] = '0;
            endcase
        end
        a_op = a_vec[ms.acomp];
        b_op = b_vec[ms.bcomp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= i_cmd.mul_en;
        end
        r_ms   <= ms;
        r_prod <= a_op * b_op;
    end

    // Accumulate the registered product into its destination.
    always_comb begin
        case (r_ms.dst)
            rtnh_pkg::D_P:   acc_cur = SW'(r_p[r_ms.dcomp]);
            rtnh_pkg::D_Q:   acc_cur = SW'(r_q[r_ms.dcomp]);
            rtnh_pkg::D_DET: acc_cur = r_det;
            rtnh_pkg::D_U:   acc_cur = r_u;
            rtnh_pkg::D_V:   acc_cur = r_v;
            rtnh_pkg::D_N:   acc_cur = r_n;
            default:         acc_cur = '0;
        endcase
        acc_base = r_ms.first ? '0 : acc_cur;
        acc_res  = r_ms.sub ? acc_base - SW'(r_prod) : acc_base + SW'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (r_mv) begin
            case (r_ms.dst)
                rtnh_pkg::D_P:   r_p[r_ms.dcomp] <= acc_res[PW-1:0];
                rtnh_pkg::D_Q:   r_q[r_ms.dcomp] <= acc_res[PW-1:0];
                rtnh_pkg::D_DET: r_det <= acc_res;
                rtnh_pkg::D_U:   r_u   <= acc_res;
                rtnh_pkg::D_V:   r_v   <= acc_res;
                rtnh_pkg::D_N:   r_n   <= acc_res;
                default: ;
            endcase
        end
    end

    // Front-face hit test; a zero threshold behaves as one.
    always_comb begin
        dmin  = (r_det_min == 16'd0) ? SW'(1) : $signed(SW'(r_det_min));
        uv    = (SW+1)'(r_u) + (SW+1)'(r_v);
        det_x = (SW+1)'(r_det);
        ok    = (r_det >= dmin) && !r_u[SW-1] && (r_u <= r_det) && !r_v[SW-1] && (uv <= det_x);
    end

    // Divider: the magnitude is compared against det shifted to each quotient bit.
    always_comb begin
        num_sh  = RW'(r_nabs) << rtnh_pkg::QUOT_SHIFT;
        det_top = RW'($unsigned(r_det)) << (DW - 1);
        ge      = (r_rem >= r_dsh);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_hit  <= ok;
            r_neg  <= r_n[SW-1];
            r_nabs <= r_n[SW-1] ? $unsigned(-r_n) : $unsigned(r_n);
        end
        if (i_cmd.div_init) begin
            r_sat <= (num_sh >= det_top);
            r_rem <= num_sh;
            r_dsh <= RW'($unsigned(r_det)) << (DW - 2);
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? r_rem - r_dsh : r_rem;
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[DW-3:0], ge};
        end
    end

    always_comb begin
        lim      = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        mag      = r_sat ? lim : {1'b0, r_quo};
        sdist    = r_neg ? $signed(-mag) : $signed(mag);
        res_dist = r_hit ? sdist : rtnh_pkg::DIST_MAX;
        new_near = (res_dist < r_near) ? res_dist : r_near;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= rtnh_pkg::DIST_MAX;
        end else if (i_cmd.out_load) begin
            r_near <= r_last ? rtnh_pkg::DIST_MAX : new_near;
        end
        if (i_cmd.out_load) begin
            r_out.hit        <= r_hit;
            r_out.distance   <= res_dist;
            r_out.nearest    <= new_near;
            r_out.batch_done <= r_last;
        end
    end

    assign o_sts.hit = r_hit;
    assign o_data    = r_out;

endmodule

// ===== rtl/rtnh_ctrl.sv =====
// Controller: sequences load, multiply steps, hit test, division and the
// hand-over to the result register. Depends on rtnh_pkg.
module rtnh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  rtnh_pkg::t_sts i_sts,
    output rtnh_pkg::t_cmd o_cmd
);

    localparam int SWD = rtnh_pkg::STEP_W;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DRAIN, S_CHECK, S_DIVINIT, S_DIV, S_OUT
    } t_state;

    t_state         r_state, n_state;
    logic [SWD-1:0] r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_cmd.step  = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_cnt == SWD'(rtnh_pkg::MUL_STEPS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_DIVINIT;
            end
            S_DIVINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = i_sts.hit ? S_DIV : S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == SWD'(rtnh_pkg::DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                // The result register is free, or is emptied at this edge.
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/ray_triangle_nearest_hit.sv =====
// Ray/triangle nearest-hit block: top level joining controller and datapath.
// Depends on rtnh_pkg, rtnh_ctrl and rtnh_datapath.
//
// The ray is set through the configuration channel (i_cfg_valid/o_cfg_ready,
// index and data): origin x/y/z, direction x/y/z and the determinant threshold.
// Writes are taken in any cycle but must only be made while the block is idle.
// Triangles arrive on i_valid/o_stall with i_data; one result per triangle
// leaves on o_valid/i_stall with o_data, in order.
// One triangle is processed at a time. It steps through the shared multiplier
// (two cross products and four dot products), then the drain, check and
// divider-start states, for a hit the one-bit-per-cycle divider, and last
// the hand-over to the output register.
// A finished result sits in the output register; while the receiver stalls,
// the block still accepts and computes the next request and holds it until
// the output register is free.
// Reset clears the ray to origin zero, direction +z, threshold one, empties the
// output register and sets the running nearest distance to its largest value.
module ray_triangle_nearest_hit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rtnh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtnh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  rtnh_pkg::t_tri_in                i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output rtnh_pkg::t_hit_out               o_data
);

    rtnh_pkg::t_cmd cmd;
    rtnh_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    rtnh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rtnh_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data      (i_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_data      (o_data)
    );

endmodule

// ===== rtl/rtnh_checker.sv =====
// Port-level checks for the ray/triangle nearest-hit block, bound to the top
// level. Depends on rtnh_pkg.
module rtnh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input rtnh_pkg::t_hit_out o_data
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while busy");

    a_miss_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.hit |-> o_data.distance == rtnh_pkg::DIST_MAX)
        else $error("miss without largest distance");

    a_near_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.nearest <= o_data.distance)
        else $error("nearest exceeds distance");

endmodule

bind ray_triangle_nearest_hit rtnh_checker u_rtnh_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for ray_triangle_nearest_hit: drives triangle streams under
// several ray settings and checks every result against an in-bench integer predictor.
// Depends on rtnh_pkg and the RTL of the block.
module tb_top;

    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 80;
    localparam int CW          = rtnh_pkg::COORD_WIDTH;
    localparam int DW          = rtnh_pkg::DIST_WIDTH;
    localparam logic [rtnh_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rtnh_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rtnh_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    rtnh_pkg::t_tri_in               i_data = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    rtnh_pkg::t_hit_out              o_data;

    ray_triangle_nearest_hit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the ray registers and the running minimum.
    logic signed [CW-1:0] ray_org[3];
    logic signed [CW-1:0] ray_dir[3];
    logic [15:0]          ray_det_min;
    logic signed [DW-1:0] nearest_so_far;

    rtnh_pkg::t_hit_out hit_q[$];
    int       err_cnt = 0;
    bit       quiet_tx = 1'b0;
    bit       quiet_rx = 1'b0;
    int       hold_req = 0;
    int       hold_left = 0;
    int       stall_left = 0;
    int       idle_cnt = 0;

    function automatic logic signed [127:0] dot_prod(logic signed [127:0] x[3],
                                                     logic signed [127:0] y[3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    task automatic cross_prod(input logic signed [127:0] x[3], input logic signed [127:0] y[3],
                              output logic signed [127:0] r[3]);
        r[0] = x[1] * y[2] - x[2] * y[1];
        r[1] = x[2] * y[0] - x[0] * y[2];
        r[2] = x[0] * y[1] - x[1] * y[0];
    endtask

    task automatic predict_hit(input rtnh_pkg::t_tri_in tr, output rtnh_pkg::t_hit_out res);
        logic signed [127:0] va[3], vb[3], vc[3], org[3], dir[3];
        logic signed [127:0] e1[3], e2[3], tv[3], pv[3], qv[3];
        logic signed [127:0] det, u, v, num, dmin;
        logic [127:0]        mag, quo, lim;
        logic signed [DW-1:0] res_dist;
        bit                  neg;
        va[0] = tr.a_x; va[1] = tr.a_y; va[2] = tr.a_z;
        vb[0] = tr.b_x; vb[1] = tr.b_y; vb[2] = tr.b_z;
        vc[0] = tr.c_x; vc[1] = tr.c_y; vc[2] = tr.c_z;
        for (int i = 0; i < 3; i++) begin
            org[i] = ray_org[i];
            dir[i] = ray_dir[i];
            e1[i]  = vb[i] - va[i];
            e2[i]  = vc[i] - va[i];
            tv[i]  = org[i] - va[i];
        end
        dmin = (ray_det_min == 0) ? 128'sd1 : $signed({112'd0, ray_det_min});
        res_dist = rtnh_pkg::DIST_MAX;
        res.hit = 1'b0;
        cross_prod(dir, e2, pv);
        cross_prod(tv, e1, qv);
        det = dot_prod(e1, pv);
        u   = dot_prod(tv, pv);
        v   = dot_prod(dir, qv);
        if (det >= dmin && u >= 0 && u <= det && v >= 0 && u + v <= det) begin
            res.hit = 1'b1;
            num = dot_prod(e2, qv);
            neg = num < 0;
            mag = neg ? -num : num;
            quo = (mag << rtnh_pkg::QUOT_SHIFT) / det;
            lim = (128'd1 << (DW - 1)) - (neg ? 0 : 1);
            if (quo > lim)
                quo = lim;
            res_dist = neg ? -quo[DW-1:0] : quo[DW-1:0];
        end
        if (res_dist < nearest_so_far)
            nearest_so_far = res_dist;
        res.distance   = res_dist;
        res.nearest    = nearest_so_far;
        res.batch_done = tr.last_triangle;
        if (tr.last_triangle)
            nearest_so_far = rtnh_pkg::DIST_MAX;
    endtask

    // The valid is left high at the end so that back-to-back requests never drop it.
    task automatic send_triangle(input rtnh_pkg::t_tri_in tr);
        rtnh_pkg::t_hit_out res;
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= tr;
        do @(posedge i_clk); while (o_stall);
        predict_hit(tr, res);
        hit_q.push_back(res);
    endtask

    task automatic write_reg(input logic [rtnh_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rtnh_pkg::CFG_ORIGIN_X: ray_org[0] = val;
            rtnh_pkg::CFG_ORIGIN_Y: ray_org[1] = val;
            rtnh_pkg::CFG_ORIGIN_Z: ray_org[2] = val;
            rtnh_pkg::CFG_DIR_X:    ray_dir[0] = val;
            rtnh_pkg::CFG_DIR_Y:    ray_dir[1] = val;
            rtnh_pkg::CFG_DIR_Z:    ray_dir[2] = val;
            rtnh_pkg::CFG_DET_MIN:  ray_det_min = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (hit_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_ray(input logic [15:0] ox, oy, oz, dx, dy, dz, dm);
        wait_idle();
        write_reg(rtnh_pkg::CFG_ORIGIN_X, ox);
        write_reg(rtnh_pkg::CFG_ORIGIN_Y, oy);
        write_reg(rtnh_pkg::CFG_ORIGIN_Z, oz);
        write_reg(rtnh_pkg::CFG_DIR_X, dx);
        write_reg(rtnh_pkg::CFG_DIR_Y, dy);
        write_reg(rtnh_pkg::CFG_DIR_Z, dz);
        write_reg(rtnh_pkg::CFG_DET_MIN, dm);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic rtnh_pkg::t_tri_in make_tri(input int ax, ay, az, bx, by, bz,
                                                   cx, cy, cz, input bit last);
        rtnh_pkg::t_tri_in tr;
        tr.a_x = CW'(ax); tr.a_y = CW'(ay); tr.a_z = CW'(az);
        tr.b_x = CW'(bx); tr.b_y = CW'(by); tr.b_z = CW'(bz);
        tr.c_x = CW'(cx); tr.c_y = CW'(cy); tr.c_z = CW'(cz);
        tr.last_triangle = last;
        return tr;
    endfunction

    function automatic rtnh_pkg::t_tri_in noise_tri();
        rtnh_pkg::t_tri_in tr;
        logic [159:0]      raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        tr  = raw[$bits(rtnh_pkg::t_tri_in)-1:0];
        return tr;
    endfunction

    // A triangle placed around a point of the ray with random winding, so that
    // front hits, back faces and near misses all occur often.
    function automatic rtnh_pkg::t_tri_in ray_tri(input int spread);
        int s, pt[3], vx[9];
        s = $urandom_range(0, 8) == 0 ? -int'($urandom_range(0, 2560))
                                      : int'($urandom_range(0, 6400));
        for (int i = 0; i < 3; i++)
            pt[i] = ray_org[i] + ((int'(ray_dir[i]) * s) >>> 14);
        for (int k = 0; k < 9; k++)
            vx[k] = pt[k % 3] + int'($urandom_range(0, 2 * spread)) - spread;
        return make_tri(vx[0], vx[1], vx[2], vx[3], vx[4], vx[5], vx[6], vx[7], vx[8],
                        $urandom_range(0, 7) == 0);
    endfunction

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0)
                send_triangle(noise_tri());
            else
                send_triangle(ray_tri($urandom_range(0, 3) == 0 ? 4096 : 600));
        end
    endtask

    task automatic test_reset_ray();
        // Ray from zero along +z; front face in z = 2560, then the same triangle reversed.
        send_triangle(make_tri(-256, -256, 2560, 0, 256, 2560, 256, -256, 2560, 0));
        send_triangle(make_tri(-256, -256, 2560, 256, -256, 2560, 0, 256, 2560, 0));
        // A hit behind the origin gives a negative distance.
        send_triangle(make_tri(-256, -256, -2560, 0, 256, -2560, 256, -256, -2560, 0));
        // A triangle beside the ray is missed.
        send_triangle(make_tri(1000, 1000, 2560, 1256, 1512, 2560, 1512, 1000, 2560, 1));
        send_triangle(make_tri(-32768, -32768, -32768, -32768, 32767, 32767,
                               32767, -32768, 32767, 0));
        send_triangle(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 0));
        send_triangle(make_tri(-32768, -32768, 0, 0, 32767, 0, 32767, -32768, 0, 1));
    endtask

    task automatic test_directed_rays();
        // A tiny direction makes the quotient overflow both ways.
        set_ray(0, 0, 0, 0, 0, 1, 1);
        send_triangle(make_tri(-256, -256, 25600, 0, 256, 25600, 256, -256, 25600, 0));
        send_triangle(make_tri(-256, -256, -25600, 0, 256, -25600, 256, -256, -25600, 1));
        // A zero direction never hits; a zero threshold acts as one.
        set_ray(0, 0, 0, 0, 0, 0, 0);
        send_triangle(make_tri(-256, -256, 2560, 0, 256, 2560, 256, -256, 2560, 1));
        set_ray(0, 0, 0, 0, 0, 16'h4000, 0);
        send_triangle(make_tri(-256, -256, 2560, 0, 256, 2560, 256, -256, 2560, 0));
        // The largest threshold is still below the det of both the small and the large triangle.
        set_ray(0, 0, 0, 0, 0, 16'h4000, 16'hFFFF);
        send_triangle(make_tri(-256, -256, 2560, 0, 256, 2560, 256, -256, 2560, 0));
        send_triangle(make_tri(-8192, -8192, 2560, 0, 8192, 2560, 8192, -8192, 2560, 1));
        // Extreme ray registers, and an out-of-range index that must change nothing.
        set_ray(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1);
        @(posedge i_clk);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                               32767, -32768, 0, 0));
        send_random(6);
    endtask

    task automatic test_random_rays();
        for (int ph = 0; ph < 6; ph++) begin
            set_ray(16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048),
                    16'($urandom_range(0, 4095) - 2048),
                    16'($urandom_range(0, 32767) - 16384),
                    16'($urandom_range(0, 32767) - 16384),
                    16'($urandom_range(0, 32767) - 16384),
                    ph == 3 ? 16'hFFFF : 16'($urandom_range(0, 64)));
            quiet_tx = (ph == 2);
            quiet_rx = (ph == 2) || (ph == 4);
            send_random(90);
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    task automatic test_backpressure();
        set_ray(0, 0, 0, 16'h0800, 16'hF800, 16'h3C00, 4);
        quiet_tx = 1'b1;
        hold_req = 300;
        send_random(20);
        quiet_tx = 1'b0;
        // The sender waits for every result before going on.
        wait_idle();
        send_random(40);
    endtask

    // Receiver: random stall per result, quiet stretches and a long hold-off.
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req > 0 || hold_left > 0) begin
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            n = stall_left;
            if (o_valid && !i_stall)
                n = quiet_rx ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
                stall_left = n - 1;
                i_stall <= 1'b1;
            end else begin
                stall_left = 0;
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        rtnh_pkg::t_hit_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hit_q.size() == 0) begin
                $display("%0t: result with no request outstanding: %p", $time, o_data);
                err_cnt++;
            end else begin
                want = hit_q.pop_front();
                if (o_data.hit !== want.hit) begin
                    $display("%0t: hit expected %0d got %0d", $time, want.hit, o_data.hit);
                    err_cnt++;
                end
                if (o_data.distance !== want.distance) begin
                    $display("%0t: distance expected %0d got %0d", $time,
                             want.distance, o_data.distance);
                    err_cnt++;
                end
                if (o_data.nearest !== want.nearest) begin
                    $display("%0t: nearest expected %0d got %0d", $time,
                             want.nearest, o_data.nearest);
                    err_cnt++;
                end
                if (o_data.batch_done !== want.batch_done) begin
                    $display("%0t: batch_done expected %0d got %0d", $time,
                             want.batch_done, o_data.batch_done);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_valid && !i_stall) || (i_valid && !o_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt = idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
        ray_dir[0] = 0; ray_dir[1] = 0; ray_dir[2] = rtnh_pkg::DIR_Z_RESET;
        ray_det_min = 1;
        nearest_so_far = rtnh_pkg::DIST_MAX;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_ray();
        test_directed_rays();
        test_random_rays();
        test_backpressure();
        wait_idle();
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rtnh_pkg.sv
rtl/rtnh_datapath.sv
rtl/rtnh_ctrl.sv
rtl/ray_triangle_nearest_hit.sv
rtl/rtnh_checker.sv
tb/sv/tb_top.sv
